// ----- rtl/lcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdt_pkg: shared types and constants for the LCD timing and register block
// Counter geometry, bus register addresses, access codes and the structs
// that pass control and status between the register file and timing units.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdt_pkg;

  // Frame geometry, in machine cycles and lines
  localparam int CYCLES_PER_LINE = 114;
  localparam int LINES_PER_FRAME = 154;
  localparam int VISIBLE_LINES   = 144;
  localparam int SEARCH_CYCLES   = 20;
  localparam int TRANSFER_END    = 63;

  localparam int CYCLE_W = 7;
  localparam int LINE_W  = 8;

  localparam logic [CYCLE_W-1:0] CYCLE_LAST   = CYCLE_W'(CYCLES_PER_LINE - 1);
  localparam logic [CYCLE_W-1:0] SEARCH_END   = CYCLE_W'(SEARCH_CYCLES);
  localparam logic [CYCLE_W-1:0] TRANSFER_LIM = CYCLE_W'(TRANSFER_END);
  localparam logic [LINE_W-1:0]  LINE_LAST    = LINE_W'(LINES_PER_FRAME - 1);
  localparam logic [LINE_W-1:0]  LINE_VBLANK  = LINE_W'(VISIBLE_LINES);

  // Access codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Register addresses
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_SCY  = 16'hFF42;
  localparam logic [15:0] ADDR_SCX  = 16'hFF43;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;
  localparam logic [15:0] ADDR_BGP  = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
  localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
  localparam logic [15:0] ADDR_WY   = 16'hFF4A;
  localparam logic [15:0] ADDR_WX   = 16'hFF4B;

  // LCD modes
  localparam logic [1:0] MODE_HBLANK   = 2'd0;
  localparam logic [1:0] MODE_VBLANK   = 2'd1;
  localparam logic [1:0] MODE_SEARCH   = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

  // Status enable bit positions
  localparam int EN_HBLANK  = 0;
  localparam int EN_VBLANK  = 1;
  localparam int EN_SEARCH  = 2;
  localparam int EN_COMPARE = 3;

  localparam int LCDC_ON_BIT = 7;

  // Register file to timing unit
  typedef struct packed {
    logic [3:0]        stat_en;
    logic [LINE_W-1:0] lyc;
    logic              lcd_on;
    logic              line_clear;
  } lcdt_ctl_t;

  // Timing unit to register file (current state, for reads)
  typedef struct packed {
    logic [LINE_W-1:0] line_reg;
    logic              coincidence;
    logic [1:0]        mode;
  } lcdt_status_t;

  // Timing unit results after this step
  typedef struct packed {
    logic [1:0]        mode;
    logic [LINE_W-1:0] line_reg;
    logic              oam_blk;
    logic              vram_blk;
    logic              stat_irq;
    logic              vblank_irq;
    logic              frame_done;
  } lcdt_tick_t;

endpackage

`default_nettype wire

// ----- rtl/lcdt_if.sv -----
// ----------------------------------------------------------------------------
// lcdt_if: valid/ready channels of the LCD timing and register block
// Item channel (tick or bus access) and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdt_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, operation, address, write_data, input ready);
  modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface lcdt_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] lcd_mode;
  logic [7:0] line_shown;
  logic       stat_irq;
  logic       vblank_irq;
  logic       oam_blocked;
  logic       vram_blocked;
  logic       frame_done;
  logic       dma_start;
  logic [7:0] dma_page;

  modport source (output valid, read_data, lcd_mode, line_shown, stat_irq, vblank_irq,
                  oam_blocked, vram_blocked, frame_done, dma_start, dma_page,
                  input ready);
  modport sink   (input valid, read_data, lcd_mode, line_shown, stat_irq, vblank_irq,
                  oam_blocked, vram_blocked, frame_done, dma_start, dma_page,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/lcdt_regs.sv -----
// ----------------------------------------------------------------------------
// lcdt_regs: bus register file
// Holds control, status enables, scroll, compare, DMA, palette and window
// registers; decodes writes and muxes reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdt_regs
  import lcdt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire op_t          op,
  input  wire logic [15:0]  addr,
  input  wire logic [7:0]   wdata,
  input  wire lcdt_status_t status,
  output lcdt_ctl_t         ctl,
  output logic [7:0]        read_data,
  output logic              dma_start,
  output logic [7:0]        dma_page_next
);

  logic [7:0] lcd_control;
  logic [3:0] stat_enables;
  logic [7:0] scy, scx, lyc, dma, bgp, obp0, obp1, wy, wx;
  logic       wr;

  assign wr = step && (op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control  <= '0;
      stat_enables <= '0;
      scy <= '0; scx <= '0; lyc <= '0; dma <= '0; bgp <= '0;
      obp0 <= '0; obp1 <= '0; wy <= '0; wx <= '0;
    end else if (wr) begin
      unique case (addr)
        ADDR_LCDC: lcd_control  <= wdata;
        ADDR_STAT: stat_enables <= wdata[6:3];
        ADDR_SCY:  scy  <= wdata;
        ADDR_SCX:  scx  <= wdata;
        ADDR_LYC:  lyc  <= wdata;
        ADDR_DMA:  dma  <= wdata;
        ADDR_BGP:  bgp  <= wdata;
        ADDR_OBP0: obp0 <= wdata;
        ADDR_OBP1: obp1 <= wdata;
        ADDR_WY:   wy   <= wdata;
        ADDR_WX:   wx   <= wdata;
        default: ;
      endcase
    end
  end

  // Read mux; the DMA register and unmapped addresses read as zero
  always_comb begin
    read_data = '0;
    if (step && (op == OP_READ)) begin
      unique case (addr)
        ADDR_LCDC: read_data = lcd_control;
        ADDR_STAT: read_data = {1'b1, stat_enables, status.coincidence, status.mode};
        ADDR_SCY:  read_data = scy;
        ADDR_SCX:  read_data = scx;
        ADDR_LY:   read_data = status.line_reg;
        ADDR_LYC:  read_data = lyc;
        ADDR_BGP:  read_data = bgp;
        ADDR_OBP0: read_data = obp0;
        ADDR_OBP1: read_data = obp1;
        ADDR_WY:   read_data = wy;
        ADDR_WX:   read_data = wx;
        default:   read_data = '0;
      endcase
    end
  end

  assign dma_start     = wr && (addr == ADDR_DMA);
  assign dma_page_next = dma_start ? wdata : dma;

  assign ctl.stat_en    = stat_enables;
  assign ctl.lyc        = lyc;
  assign ctl.lcd_on     = lcd_control[LCDC_ON_BIT];
  assign ctl.line_clear = wr && (addr == ADDR_LY);

endmodule

`default_nettype wire

// ----- rtl/lcdt_timing.sv -----
// ----------------------------------------------------------------------------
// lcdt_timing: line and frame timing, mode and status interrupt
// Advances the cycle and line counters on each tick, picks the mode and
// memory access blocks, and edge-detects the combined status line.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdt_timing
  import lcdt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      tick,
  input  wire lcdt_ctl_t ctl,
  output lcdt_status_t   status,
  output lcdt_tick_t     res
);

  logic [CYCLE_W-1:0] cycle_count, cycle_count_next;
  logic [LINE_W-1:0]  line_count, line_count_next;
  logic [LINE_W-1:0]  line_register, line_register_next;
  logic [1:0]         mode_bits, mode_bits_next;
  logic               coincidence, coincidence_next;
  logic               stat_line_last, stat_line_last_next;
  logic [1:0]         access_blocks, access_blocks_next;
  logic               visible, src, eq, cur;

  always_comb begin
    cycle_count_next    = cycle_count;
    line_count_next     = line_count;
    line_register_next  = line_register;
    mode_bits_next      = mode_bits;
    coincidence_next    = coincidence;
    stat_line_last_next = stat_line_last;
    access_blocks_next  = access_blocks;
    res.stat_irq        = 1'b0;
    res.vblank_irq      = 1'b0;
    res.frame_done      = 1'b0;
    visible             = line_count < LINE_VBLANK;
    src                 = 1'b0;
    eq                  = ctl.lyc == line_register;
    cur                 = 1'b0;

    if (ctl.line_clear) begin
      line_register_next = '0;
    end

    if (tick) begin
      // Mode, access blocks and status source; mode holds on search cycle zero
      if (visible && (cycle_count < SEARCH_END)) begin
        src = ctl.stat_en[EN_SEARCH];
        access_blocks_next = access_blocks | 2'b01;
        if (cycle_count != '0) begin
          mode_bits_next = MODE_SEARCH;
        end
      end else if (visible && (cycle_count < TRANSFER_LIM)) begin
        access_blocks_next = 2'b11;
        mode_bits_next     = MODE_TRANSFER;
      end else if (visible) begin
        src = ctl.stat_en[EN_HBLANK];
        access_blocks_next = 2'b00;
        mode_bits_next     = MODE_HBLANK;
      end else begin
        src = ctl.stat_en[EN_VBLANK] | ctl.stat_en[EN_SEARCH];
        access_blocks_next = 2'b00;
        mode_bits_next     = MODE_VBLANK;
      end

      cur                 = src | (eq & ctl.stat_en[EN_COMPARE]);
      res.stat_irq        = cur & ~stat_line_last;
      stat_line_last_next = cur;
      coincidence_next    = eq;

      res.vblank_irq = (line_count == LINE_VBLANK) && (cycle_count == '0) && ctl.lcd_on;

      // Advance counters
      if (cycle_count == CYCLE_LAST) begin
        if (line_count == LINE_LAST) begin
          line_count_next = '0;
          res.frame_done  = 1'b1;
        end else begin
          line_count_next = line_count + LINE_W'(1);
        end
        line_register_next = line_count_next;
        cycle_count_next   = '0;
      end else begin
        cycle_count_next = cycle_count + CYCLE_W'(1);
      end

      // Last line of the frame shows as line zero after its first cycle
      if ((line_count_next == LINE_LAST) && (cycle_count_next != '0)) begin
        line_register_next = '0;
      end
    end

    res.mode     = mode_bits_next;
    res.line_reg = line_register_next;
    res.oam_blk  = access_blocks_next[0];
    res.vram_blk = access_blocks_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count    <= '0;
      line_count     <= '0;
      line_register  <= '0;
      mode_bits      <= '0;
      coincidence    <= 1'b0;
      stat_line_last <= 1'b0;
      access_blocks  <= '0;
    end else begin
      cycle_count    <= cycle_count_next;
      line_count     <= line_count_next;
      line_register  <= line_register_next;
      mode_bits      <= mode_bits_next;
      coincidence    <= coincidence_next;
      stat_line_last <= stat_line_last_next;
      access_blocks  <= access_blocks_next;
    end
  end

  assign status.line_reg    = line_register;
  assign status.coincidence = coincidence;
  assign status.mode        = mode_bits;

  a_cycle_range: assert property (@(posedge clk) disable iff (rst)
    cycle_count <= CYCLE_LAST)
    else $error("cycle counter past end of line");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    line_count <= LINE_LAST)
    else $error("line counter past end of frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    tick && res.frame_done |=> (line_count == '0) && (cycle_count == '0))
    else $error("frame end without counter wrap");

  a_vram_implies_oam: assert property (@(posedge clk) disable iff (rst)
    access_blocks[1] |-> access_blocks[0])
    else $error("video memory blocked while object memory open");

  a_transfer_blocks: assert property (@(posedge clk) disable iff (rst)
    (mode_bits == MODE_TRANSFER) |-> (access_blocks == 2'b11))
    else $error("transfer mode without both access blocks");

endmodule

`default_nettype wire

// ----- rtl/lcdt_timing_and_register_block_core.sv -----
// ----------------------------------------------------------------------------
// lcd_timing_and_register_block_core: LCD timing and register block
// Path: an item word taken into the input register moves into the result
//   register on a step, which waits until the result register frees up.
// Throughput: one word per cycle while results are taken; the register file
//   and timing unit finish an item combinationally between the two registers.
// Reset (rst, synchronous): counters, mode, access blocks, all bus registers
//   and both channel valid flags clear together; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_timing_and_register_block_core
  import lcdt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  lcdt_item_if.sink      item,
  lcdt_result_if.source  result
);

  // Input register
  logic        item_valid;
  op_t         item_op;
  logic [15:0] item_addr;
  logic [7:0]  item_data;

  // Result register
  logic        res_valid;
  logic [7:0]  res_read_data;
  logic [1:0]  res_mode;
  logic [7:0]  res_line;
  logic        res_stat_irq;
  logic        res_vblank_irq;
  logic        res_oam_blk;
  logic        res_vram_blk;
  logic        res_frame_done;
  logic        res_dma_start;
  logic [7:0]  res_dma_page;

  logic         advance, step, take;
  lcdt_ctl_t    ctl;
  lcdt_status_t status;
  lcdt_tick_t   tick_res;
  logic [7:0]   read_data;
  logic         dma_start;
  logic [7:0]   dma_page_next;

  // The result register frees up when empty or when its word is taken;
  // the input register then hands its item across and can reload in the
  // same cycle; a stalled result blocks accepts only when the input is full.
  assign advance    = !res_valid || result.ready;
  assign step       = item_valid && advance;
  assign item.ready = !item_valid || advance;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  // Capture payload on accept; no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      item_op   <= op_t'(item.operation);
      item_addr <= item.address;
      item_data <= item.write_data;
    end
  end

  lcdt_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .op            (item_op),
    .addr          (item_addr),
    .wdata         (item_data),
    .status        (status),
    .ctl           (ctl),
    .read_data     (read_data),
    .dma_start     (dma_start),
    .dma_page_next (dma_page_next)
  );

  lcdt_timing u_timing (
    .clk    (clk),
    .rst    (rst),
    .tick   (step && (item_op == OP_TICK)),
    .ctl    (ctl),
    .status (status),
    .res    (tick_res)
  );

  // Result valid: set on each step, drop once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Hold the result word until a new step replaces it
  always_ff @(posedge clk) begin
    if (step) begin
      res_read_data  <= read_data;
      res_mode       <= tick_res.mode;
      res_line       <= tick_res.line_reg;
      res_stat_irq   <= tick_res.stat_irq;
      res_vblank_irq <= tick_res.vblank_irq;
      res_oam_blk    <= tick_res.oam_blk;
      res_vram_blk   <= tick_res.vram_blk;
      res_frame_done <= tick_res.frame_done;
      res_dma_start  <= dma_start;
      res_dma_page   <= dma_page_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.read_data    = res_read_data;
  assign result.lcd_mode     = res_mode;
  assign result.line_shown   = res_line;
  assign result.stat_irq     = res_stat_irq;
  assign result.vblank_irq   = res_vblank_irq;
  assign result.oam_blocked  = res_oam_blk;
  assign result.vram_blocked = res_vram_blk;
  assign result.frame_done   = res_frame_done;
  assign result.dma_start    = res_dma_start;
  assign result.dma_page     = res_dma_page;

endmodule

`default_nettype wire

// ----- tb/sv/lcd_timing_and_register_block_core_tb.sv -----
// ----------------------------------------------------------------------------
// lcd_timing_and_register_block_core_tb: self-checking bench for the LCD core
// Sends tick, read and write words through the item channel and predicts
// every result word with an in-bench model of the line and frame timing,
// mode and access blocks, status and vblank interrupts, and bus registers.
// Random idle cycles fall on both channels; results are checked per field.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_timing_and_register_block_core_tb;
  import lcdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation code that the block decodes as "do nothing"
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int QUIET_LIMIT  = 2000;   // cycles with no word moving on either channel
  localparam int RANDOM_WORDS = 1000;
  localparam int SWEEP_TICKS  = 2 * CYCLES_PER_LINE;
  localparam int NO_IDLE_FROM = 300;    // window of cycles with no idling at all
  localparam int NO_IDLE_TO   = 900;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] lcd_mode;
    logic [7:0] line_shown;
    logic       stat_irq;
    logic       vblank_irq;
    logic       oam_blocked;
    logic       vram_blocked;
    logic       frame_done;
    logic       dma_start;
    logic [7:0] dma_page;
  } lcd_view_t;

  logic clk;
  logic rst;

  lcdt_item_if   item_ch ();
  lcdt_result_if result_ch ();

  lcd_timing_and_register_block_core uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // LCD state as the bench expects it; reset values are all zero
  // --------------------------------------------------------------------------
  logic [6:0] lcd_cycle   = '0;  // machine cycle within the line
  logic [7:0] lcd_line    = '0;  // line counter within the frame
  logic [7:0] ly_shown    = '0;  // visible line register
  logic [7:0] lcdc_q      = '0;
  logic [3:0] stat_en_q   = '0;
  logic [1:0] mode_q      = '0;
  logic       coin_q      = 1'b0;
  logic       stat_line_q = 1'b0;
  logic [1:0] blocks_q    = '0;  // bit0 object memory, bit1 video memory
  // Plain registers indexed by the low address nibble; LCDC, STAT and LY
  // slots are never touched here
  logic [7:0] plain_q [12] = '{default: '0};

  bus_word_t pending_words [$];   // words waiting for the driver
  lcd_view_t expected_views [$];  // predicted result words, oldest first
  bus_word_t drv_word;            // word currently presented on the item channel

  int unsigned cycle_n;
  int unsigned quiet_cycles;
  int unsigned bad_views;

  // Advance the LCD state by one accepted word and return the result word
  function automatic lcd_view_t advance_lcd(bus_word_t w);
    lcd_view_t v;
    int        c;
    int        l;
    logic      src;
    logic      cur;
    logic      eq;
    v = '0;
    case (w.operation)
      OP_TICK: begin
        c   = lcd_cycle;
        l   = lcd_line;
        src = 1'b0;
        if (l < VISIBLE_LINES) begin
          if (c < SEARCH_CYCLES) begin
            // object search; on cycle zero the mode bits hold their old value
            src         = stat_en_q[EN_SEARCH];
            blocks_q[0] = 1'b1;
            if (c >= 1) mode_q = MODE_SEARCH;
          end else if (c < TRANSFER_END) begin
            // transfer raises no status source
            blocks_q = 2'b11;
            mode_q   = MODE_TRANSFER;
          end else begin
            src      = stat_en_q[EN_HBLANK];
            blocks_q = 2'b00;
            mode_q   = MODE_HBLANK;
          end
        end else begin
          // vblank answers to either the vblank or the search enable
          src      = stat_en_q[EN_VBLANK] | stat_en_q[EN_SEARCH];
          blocks_q = 2'b00;
          mode_q   = MODE_VBLANK;
        end
        // compare source is ORed with the mode source
        eq          = (plain_q[ADDR_LYC[3:0]] == ly_shown);
        cur         = src | (eq & stat_en_q[EN_COMPARE]);
        v.stat_irq  = cur & ~stat_line_q;
        stat_line_q = cur;
        coin_q      = eq;
        // vblank pulse is the only thing gated by the display enable
        v.vblank_irq = (l == VISIBLE_LINES) && (c == 0) && lcdc_q[LCDC_ON_BIT];
        if (c == CYCLES_PER_LINE - 1) begin
          if (l == LINES_PER_FRAME - 1) begin
            l            = 0;
            v.frame_done = 1'b1;
          end else begin
            l++;
          end
          ly_shown = 8'(l);
          c        = 0;
        end else begin
          c++;
        end
        lcd_cycle = 7'(c);
        lcd_line  = 8'(l);
        // last line of the frame reads as line 0 after its first cycle
        if (lcd_line == LINES_PER_FRAME - 1 && lcd_cycle >= 1) ly_shown = '0;
      end
      OP_READ: begin
        if (w.address >= ADDR_LCDC && w.address <= ADDR_WX) begin
          case (w.address)
            ADDR_LCDC: v.read_data = lcdc_q;
            ADDR_STAT: v.read_data = {1'b1, stat_en_q, coin_q, mode_q};
            ADDR_LY:   v.read_data = ly_shown;
            ADDR_DMA:  v.read_data = '0;   // DMA register is write-only
            default:   v.read_data = plain_q[w.address[3:0]];
          endcase
        end
      end
      OP_WRITE: begin
        case (w.address)
          ADDR_LCDC: lcdc_q = w.write_data;
          ADDR_STAT: stat_en_q = w.write_data[6:3];
          ADDR_LY:   ly_shown = '0;   // clears the register, not the counter
          ADDR_SCY, ADDR_SCX, ADDR_LYC, ADDR_DMA, ADDR_BGP, ADDR_OBP0, ADDR_OBP1,
          ADDR_WY, ADDR_WX: begin
            plain_q[w.address[3:0]] = w.write_data;
            v.dma_start             = (w.address == ADDR_DMA);
          end
          default: ;
        endcase
      end
      default: ;   // spare code: no state change, no pulses
    endcase
    v.lcd_mode     = mode_q;
    v.line_shown   = ly_shown;
    v.oam_blocked  = blocks_q[0];
    v.vram_blocked = blocks_q[1];
    v.dma_page     = plain_q[ADDR_DMA[3:0]];
    return v;
  endfunction

  // Random bus access; compare writes favor lines up to lyc_max so that
  // coincidence actually happens
  function automatic bus_word_t random_access(int lyc_max);
    bus_word_t w;
    int        pick;
    pick         = $urandom_range(99);
    w.address    = ADDR_LCDC + 16'($urandom_range(11));
    w.write_data = 8'($urandom_range(255));
    if (pick < 45) begin
      w.operation = OP_WRITE;
      if (w.address == ADDR_LYC && $urandom_range(3) != 0)
        w.write_data = 8'($urandom_range(lyc_max));
    end else if (pick < 90) begin
      w.operation = OP_READ;
    end else if (pick < 96) begin
      // noise: any code at any address
      w.operation = 2'($urandom_range(3));
      w.address   = 16'($urandom_range(65535));
    end else begin
      w.operation = OP_SPARE;
    end
    return w;
  endfunction

  function automatic bit take_break();
    return !(cycle_n >= NO_IDLE_FROM && cycle_n < NO_IDLE_TO) && ($urandom_range(99) < 13);
  endfunction

  function automatic bus_word_t make_word(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
    bus_word_t w;
    w.operation  = op;
    w.address    = addr;
    w.write_data = data;
    return w;
  endfunction

  task automatic note_mismatch(string field, logic [7:0] exp_v, logic [7:0] act_v);
    $error("%s: expected %0h, got %0h", field, exp_v, act_v);
  endtask

  task automatic check_view(lcd_view_t e, lcd_view_t a);
    bit bad;
    bad = 1'b0;
    if (e.read_data !== a.read_data) begin
      bad = 1'b1;
      note_mismatch("read_data", e.read_data, a.read_data);
    end
    if (e.lcd_mode !== a.lcd_mode) begin
      bad = 1'b1;
      note_mismatch("lcd_mode", e.lcd_mode, a.lcd_mode);
    end
    if (e.line_shown !== a.line_shown) begin
      bad = 1'b1;
      note_mismatch("line_shown", e.line_shown, a.line_shown);
    end
    if (e.stat_irq !== a.stat_irq) begin
      bad = 1'b1;
      note_mismatch("stat_irq", e.stat_irq, a.stat_irq);
    end
    if (e.vblank_irq !== a.vblank_irq) begin
      bad = 1'b1;
      note_mismatch("vblank_irq", e.vblank_irq, a.vblank_irq);
    end
    if (e.oam_blocked !== a.oam_blocked) begin
      bad = 1'b1;
      note_mismatch("oam_blocked", e.oam_blocked, a.oam_blocked);
    end
    if (e.vram_blocked !== a.vram_blocked) begin
      bad = 1'b1;
      note_mismatch("vram_blocked", e.vram_blocked, a.vram_blocked);
    end
    if (e.frame_done !== a.frame_done) begin
      bad = 1'b1;
      note_mismatch("frame_done", e.frame_done, a.frame_done);
    end
    if (e.dma_start !== a.dma_start) begin
      bad = 1'b1;
      note_mismatch("dma_start", e.dma_start, a.dma_start);
    end
    if (e.dma_page !== a.dma_page) begin
      bad = 1'b1;
      note_mismatch("dma_page", e.dma_page, a.dma_page);
    end
    if (bad) bad_views++;
  endtask

  // Hold until every queued word is taken and every result word is back.
  // Sampled on the falling edge so the rising-edge blocks have settled.
  task automatic drain();
    while (pending_words.size() != 0 || item_ch.valid || expected_views.size() != 0)
      @(negedge clk);
  endtask

  // Drive every channel input to a known value from time zero
  initial begin
    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.operation  = OP_TICK;
    item_ch.address    = '0;
    item_ch.write_data = '0;
    result_ch.ready    = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Driver: predict each word as it is taken, then present the next one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      // word taken at this edge: run it through the model now
      if (item_ch.valid && item_ch.ready)
        expected_views.push_back(advance_lcd(drv_word));
      // slot is free: either offer the next word or idle
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_words.size() != 0 && !take_break()) begin
          drv_word            = pending_words.pop_front();
          item_ch.valid      <= 1'b1;
          item_ch.operation  <= drv_word.operation;
          item_ch.address    <= drv_word.address;
          item_ch.write_data <= drv_word.write_data;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lcd_view_t act;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        act.read_data    = result_ch.read_data;
        act.lcd_mode     = result_ch.lcd_mode;
        act.line_shown   = result_ch.line_shown;
        act.stat_irq     = result_ch.stat_irq;
        act.vblank_irq   = result_ch.vblank_irq;
        act.oam_blocked  = result_ch.oam_blocked;
        act.vram_blocked = result_ch.vram_blocked;
        act.frame_done   = result_ch.frame_done;
        act.dma_start    = result_ch.dma_start;
        act.dma_page     = result_ch.dma_page;
        if (expected_views.size() == 0) begin
          $error("result word arrived with none expected");
          bad_views++;
        end else begin
          check_view(expected_views.pop_front(), act);
        end
      end
      result_ch.ready <= !take_break();
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: drop the run if nothing moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
      cycle_n      <= 0;
    end else begin
      cycle_n <= cycle_n + 1;
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("lcd_timing_and_register_block_core_tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    bad_views = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: write every register with alternating extremes (compare
    // gets zero so it matches line 0), read them all back, then the
    // spare code, unmapped reads and a write, two ticks and a status read
    for (int i = 0; i < 12; i++) begin
      if (ADDR_LCDC + 16'(i) == ADDR_LYC)
        pending_words.push_back(make_word(OP_WRITE, ADDR_LYC, 8'h00));
      else
        pending_words.push_back(make_word(OP_WRITE, ADDR_LCDC + 16'(i),
                                          (i % 2 == 0) ? 8'hFF : 8'h00));
    end
    for (int i = 0; i < 12; i++)
      pending_words.push_back(make_word(OP_READ, ADDR_LCDC + 16'(i), 8'h00));
    pending_words.push_back(make_word(OP_SPARE, 16'hFFFF, 8'hFF));
    pending_words.push_back(make_word(OP_READ, 16'h0000, 8'h00));
    pending_words.push_back(make_word(OP_READ, 16'hFF4C, 8'h00));
    pending_words.push_back(make_word(OP_WRITE, 16'hFF3F, 8'hFF));
    pending_words.push_back(make_word(OP_TICK, 16'hFFFF, 8'hFF));
    pending_words.push_back(make_word(OP_TICK, 16'h0000, 8'h00));
    pending_words.push_back(make_word(OP_READ, ADDR_STAT, 8'h00));

    // pause the sender until every result is back
    drain();

    // Random mix of ticks and bus accesses over the first few lines
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(99) < 55)
        pending_words.push_back(make_word(OP_TICK, 16'($urandom_range(65535)),
                                          8'($urandom_range(255))));
      else
        pending_words.push_back(random_access(7));
    end
    drain();

    // Line sweep: tick through two lines with the display switched on so search,
    // transfer and hblank modes and both access blocks come up back to back;
    // sprinkle accesses so enables and compare move around
    pending_words.push_back(make_word(OP_WRITE, ADDR_LCDC, 8'h91));
    for (int i = 0; i < SWEEP_TICKS; i++) begin
      pending_words.push_back(make_word(OP_TICK, 16'($urandom_range(65535)),
                                        8'($urandom_range(255))));
      if ($urandom_range(39) == 0) pending_words.push_back(random_access(LINES_PER_FRAME - 1));
    end
    drain();

    // let any stray result word show up before the verdict
    repeat (8) @(negedge clk);
    if (bad_views == 0) begin
      $display("lcd_timing_and_register_block_core_tb OK");
    end else begin
      $display("lcd_timing_and_register_block_core_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- lcd_timing_and_register_block_core.f -----
rtl/lcdt_pkg.sv
rtl/lcdt_if.sv
rtl/lcdt_regs.sv
rtl/lcdt_timing.sv
rtl/lcdt_timing_and_register_block_core.sv
tb/sv/lcd_timing_and_register_block_core_tb.sv
